@@ sv/i2cms_pkg.sv @@
// Shared types, command codes and defaults for the I2C master bit sequencer.
`default_nettype none
package i2cms_pkg;

  // Command codes as carried on the input channel and in the internal queue
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  localparam int          DELAY_BITS_DEF = 8;
  localparam int          QUEUE_DEPTH    = 2;
  localparam logic [7:0]  DELAY_RESET    = 8'd200;

  // Input item
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_byte;
    logic       sda_in;
  } in_t;

  // Result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_bit;
  } out_t;

  // Classified tick between front and back
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wr_byte;
    logic       sda_in;
  } tick_t;

endpackage
`default_nettype wire

@@ sv/i2cms_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
`default_nettype none
module i2cms_fifo #(
  parameter int W     = 12,
  parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  // Pointer and fill count
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ sv/i2cms_front.sv @@
// Front end: accepts input items, classifies the request and queues the tick.
`default_nettype none
module i2cms_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire i2cms_pkg::in_t    in_data,
  input  wire logic              q_pop,
  output logic                   q_empty,
  output i2cms_pkg::tick_t       q_data
);
  i2cms_pkg::tick_t tick;
  logic [$bits(i2cms_pkg::tick_t)-1:0] q_raw;

  // Unknown codes collapse to no command
  always_comb begin
    tick.wr_byte = in_data.wr_byte;
    tick.sda_in  = in_data.sda_in;
    case (in_data.req_type)
      i2cms_pkg::CMD_START,
      i2cms_pkg::CMD_STOP,
      i2cms_pkg::CMD_WRITE,
      i2cms_pkg::CMD_ACK,
      i2cms_pkg::CMD_READ: tick.cmd = in_data.req_type;
      default:             tick.cmd = i2cms_pkg::CMD_NONE;
    endcase
  end

  i2cms_fifo #(
    .W     ($bits(i2cms_pkg::tick_t)),
    .DEPTH (i2cms_pkg::QUEUE_DEPTH)
  ) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (tick),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_raw)
  );

  assign q_data = i2cms_pkg::tick_t'(q_raw);

endmodule
`default_nettype wire

@@ sv/i2cms_back.sv @@
// Back end: line phase sequencer, one tick per queued item, results queued out.
`default_nettype none
module i2cms_back #(
  parameter int DELAY_BITS = i2cms_pkg::DELAY_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              q_empty,
  input  wire i2cms_pkg::tick_t  q_data,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output i2cms_pkg::out_t        out_data
);
  // Phase codes
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_ST0  = 4'd1;
  localparam logic [3:0] PH_ST1  = 4'd2;
  localparam logic [3:0] PH_ST2  = 4'd3;
  localparam logic [3:0] PH_SP0  = 4'd4;
  localparam logic [3:0] PH_SP1  = 4'd5;
  localparam logic [3:0] PH_SP2  = 4'd6;
  localparam logic [3:0] PH_WA   = 4'd7;
  localparam logic [3:0] PH_WB   = 4'd8;
  localparam logic [3:0] PH_WC   = 4'd9;
  localparam logic [3:0] PH_WR   = 4'd10;
  localparam logic [3:0] PH_AK0  = 4'd11;
  localparam logic [3:0] PH_AK1  = 4'd12;
  localparam logic [3:0] PH_AK2  = 4'd13;
  localparam logic [3:0] PH_RA   = 4'd14;
  localparam logic [3:0] PH_RB   = 4'd15;

  logic [7:0]            dly_r;
  logic [3:0]            phase_r, phase_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [DELAY_BITS-1:0] dcnt_r, dcnt_nxt, dcnt_dec, load_val;
  logic [7:0]            shift_r, shift_nxt;
  logic                  scl_r, scl_nxt, sda_r, sda_nxt, ack_r, ack_nxt;
  logic                  do_enter, done;
  logic                  out_full, fire;
  i2cms_pkg::out_t       res;
  logic [$bits(i2cms_pkg::out_t)-1:0] out_raw;

  // Step when a tick is queued and there is room for its result
  assign fire  = !q_empty && !out_full;
  assign q_pop = fire;

  // Phase length, zero acts as one
  always_comb begin
    load_val = DELAY_BITS'(dly_r);
    if (load_val == '0) begin
      load_val = DELAY_BITS'(1);
    end
  end

  assign dcnt_dec = dcnt_r - DELAY_BITS'(1);

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    dcnt_nxt  = dcnt_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    do_enter  = 1'b0;
    done      = 1'b0;
    if (phase_r == PH_IDLE) begin
      case (q_data.cmd)
        i2cms_pkg::CMD_START: begin
          phase_nxt = PH_ST0;
          do_enter  = 1'b1;
        end
        i2cms_pkg::CMD_STOP: begin
          phase_nxt = PH_SP0;
          do_enter  = 1'b1;
        end
        i2cms_pkg::CMD_WRITE: begin
          shift_nxt = q_data.wr_byte;
          bit_nxt   = 3'd0;
          phase_nxt = PH_WA;
          do_enter  = 1'b1;
        end
        i2cms_pkg::CMD_ACK: begin
          phase_nxt = PH_AK0;
          do_enter  = 1'b1;
        end
        i2cms_pkg::CMD_READ: begin
          shift_nxt = 8'd0;
          bit_nxt   = 3'd0;
          phase_nxt = PH_RA;
          do_enter  = 1'b1;
        end
        default: ;
      endcase
    end else if (dcnt_dec != '0) begin
      dcnt_nxt = dcnt_dec;
    end else begin
      // Phase ran out
      do_enter = 1'b1;
      case (phase_r)
        PH_ST0: phase_nxt = PH_ST1;
        PH_ST1: phase_nxt = PH_ST2;
        PH_SP0: phase_nxt = PH_SP1;
        PH_SP1: phase_nxt = PH_SP2;
        PH_WA:  phase_nxt = PH_WB;
        PH_WB:  phase_nxt = PH_WC;
        PH_WC: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_r == 3'd7) begin
            bit_nxt   = 3'd0;
            phase_nxt = PH_WR;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_WA;
          end
        end
        PH_AK0: phase_nxt = PH_AK1;
        PH_AK1: begin
          ack_nxt   = q_data.sda_in;
          phase_nxt = PH_AK2;
        end
        PH_RA: begin
          shift_nxt = {shift_r[6:0], q_data.sda_in};
          phase_nxt = PH_RB;
        end
        PH_RB: begin
          if (bit_r == 3'd7) begin
            bit_nxt   = 3'd0;
            do_enter  = 1'b0;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_RA;
          end
        end
        default: begin
          // last phase of start, stop, write and ack
          do_enter = 1'b0;
          done     = 1'b1;
        end
      endcase
      if (done) begin
        phase_nxt = PH_IDLE;
        dcnt_nxt  = '0;
      end
    end

    // Line levels of the phase being entered
    if (do_enter) begin
      dcnt_nxt = load_val;
      case (phase_nxt)
        PH_ST0: begin sda_nxt = 1'b1; scl_nxt = 1'b1; end
        PH_ST1: sda_nxt = 1'b0;
        PH_ST2: scl_nxt = 1'b0;
        PH_SP0: begin sda_nxt = 1'b0; scl_nxt = 1'b0; end
        PH_SP1: scl_nxt = 1'b1;
        PH_SP2: sda_nxt = 1'b1;
        PH_WA:  sda_nxt = shift_nxt[7];
        PH_WB:  scl_nxt = 1'b1;
        PH_WC:  scl_nxt = 1'b0;
        PH_WR:  sda_nxt = 1'b1;
        PH_AK0: sda_nxt = 1'b1;
        PH_AK1: scl_nxt = 1'b1;
        PH_AK2: scl_nxt = 1'b0;
        PH_RA:  begin sda_nxt = 1'b1; scl_nxt = 1'b1; end
        PH_RB:  scl_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.rd_byte  = shift_nxt;
    res.ack_bit  = ack_nxt;
  end

  // Configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r   <= i2cms_pkg::DELAY_RESET;
      phase_r <= PH_IDLE;
      bit_r   <= 3'd0;
      dcnt_r  <= '0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        dly_r <= cfg_data;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        dcnt_r  <= dcnt_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
      end
    end
  end

  i2cms_fifo #(
    .W     ($bits(i2cms_pkg::out_t)),
    .DEPTH (i2cms_pkg::QUEUE_DEPTH)
  ) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .full  (out_full),
    .wdata (res),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_raw)
  );

  assign out_data = i2cms_pkg::out_t'(out_raw);

endmodule
`default_nettype wire

@@ sv/i2c_master_bit_sequencer_core.sv @@
// Top level of the I2C master bit sequencer: front queue, sequencer, result queue.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  input   | in_push, in_full, in_data      | one tick: command, byte, SDA
//  result  | out_empty, out_pop, out_data   | one line state per tick
//  config  | cfg_we, cfg_data               | delay_ticks
//
// One item per clock sustained while the result queue has room; a result shows
// on the result ports once its item has passed the front queue register and
// then the sequencer step into the result queue.
// The sequencer steps once per item, gated only by result queue room.
// rst_n is synchronous; it empties both queues and returns the bus lines high.
// A stalled result side fills the result queue, then the front queue, then
// raises in_full.
`default_nettype none
module i2c_master_bit_sequencer_core #(
  parameter int DELAY_BITS = i2cms_pkg::DELAY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire i2cms_pkg::in_t   in_data,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output i2cms_pkg::out_t       out_data,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_data
);
  logic             q_pop, q_empty;
  i2cms_pkg::tick_t q_data;

  i2cms_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  i2cms_back #(
    .DELAY_BITS (DELAY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/i2cms_checker.sv @@
// Port-level assertions for the I2C master bit sequencer, bound to the top level.
`default_nettype none
module i2cms_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_push,
  input wire logic             in_full,
  input wire logic             out_empty,
  input wire logic             out_pop,
  input wire i2cms_pkg::out_t  out_data,
  input wire logic             cfg_we
);
  // An accepted item is followed by a waiting result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> ##1 !out_empty)
    else $error("no result after accepted item");

  // Input side backs up only behind a waiting result
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full with no result waiting");

  // A completing tick is never also busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop && !cfg_we) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_chk (.*);
`default_nettype wire
